>>> rtl/hcbe_pkg.sv
// ----------------------------------------------------------------------------
// hcbe_pkg
// Shared types, character codes and helpers for the chunked body end detector.
// ----------------------------------------------------------------------------
package hcbe_pkg;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam int unsigned REG_SKIP_TRAILERS = 0;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_END  = 2'd1,
        ST_ERR  = 2'd2,
        ST_IGN  = 2'd3
    } status_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_slot_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.value = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            d.value = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        else
        begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

>>> rtl/hcbe_in_stage.sv
// ----------------------------------------------------------------------------
// hcbe_in_stage
// Input register: holds one accepted byte until the parser stage takes it.
// ----------------------------------------------------------------------------
module hcbe_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,
    input  logic                take,
    output hcbe_pkg::byte_slot_t slot
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       load;

    assign s_axis_tready = !valid_reg || take;
    assign load          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= s_axis_tdata;
        end
    end

    assign slot.valid = valid_reg;
    assign slot.data  = data_reg;

endmodule

>>> rtl/hcbe_parser.sv
// ----------------------------------------------------------------------------
// hcbe_parser
// Parser state machine, size counter and result register.
// ----------------------------------------------------------------------------
module hcbe_parser
#(
    parameter int MAX_SIZE_DIGITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hcbe_pkg::byte_slot_t slot,
    output logic                 take,
    input  logic                 skip_trailers,
    output logic                 out_valid,
    input  logic                 out_ready,
    output hcbe_pkg::status_t    out_status,
    output logic                 out_payload
);

    localparam int CNT_W = 4 * MAX_SIZE_DIGITS;
    localparam int DC_W  = $clog2(MAX_SIZE_DIGITS + 1);

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_EXT,
        PH_DATA,
        PH_CRLF,
        PH_TR_HEAD,
        PH_TR_MID,
        PH_DONE,
        PH_FAIL
    } phase_t;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [DC_W-1:0]     dcnt_reg;
    logic [DC_W-1:0]     dcnt_next;
    logic                valid_reg;
    hcbe_pkg::status_t   status_reg;
    hcbe_pkg::status_t   status_next;
    logic                payload_reg;
    logic                payload_next;
    hcbe_pkg::hex_digit_t hd;
    logic                is_lf;
    logic                is_cr;
    logic                cnt_zero;
    phase_t              ext_phase;
    hcbe_pkg::status_t   ext_status;

    assign take     = slot.valid && (!valid_reg || out_ready);
    assign hd       = hcbe_pkg::hex_decode(slot.data);
    assign is_lf    = (slot.data == hcbe_pkg::CH_LF);
    assign is_cr    = (slot.data == hcbe_pkg::CH_CR);
    assign cnt_zero = (cnt_reg == '0);

    // End of the size line: a nonzero size enters the chunk data; a zero size ends the body or enters the trailers.
    always_comb
    begin
        ext_phase  = PH_EXT;
        ext_status = hcbe_pkg::ST_BUSY;
        if (is_lf)
        begin
            if (!cnt_zero)
            begin
                ext_phase = PH_DATA;
            end
            else if (skip_trailers)
            begin
                ext_phase = PH_TR_HEAD;
            end
            else
            begin
                ext_phase  = PH_DONE;
                ext_status = hcbe_pkg::ST_END;
            end
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        dcnt_next    = dcnt_reg;
        status_next  = hcbe_pkg::ST_BUSY;
        payload_next = 1'b0;
        unique case (phase_reg)
            PH_SIZE:
            begin
                if (!hd.valid)
                begin
                    if (dcnt_reg == '0)
                    begin
                        phase_next  = PH_FAIL;
                        status_next = hcbe_pkg::ST_ERR;
                    end
                    else
                    begin
                        dcnt_next   = '0;
                        phase_next  = ext_phase;
                        status_next = ext_status;
                    end
                end
                else if (dcnt_reg >= DC_W'(MAX_SIZE_DIGITS))
                begin
                    phase_next  = PH_FAIL;
                    status_next = hcbe_pkg::ST_ERR;
                end
                else
                begin
                    cnt_next  = (cnt_reg << 4) | CNT_W'(hd.value);
                    dcnt_next = dcnt_reg + DC_W'(1);
                end
            end
            PH_EXT:
            begin
                phase_next  = ext_phase;
                status_next = ext_status;
            end
            PH_DATA:
            begin
                payload_next = 1'b1;
                if (!cnt_zero)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                if (cnt_reg[CNT_W-1:1] == '0)
                begin
                    phase_next = PH_CRLF;
                end
            end
            PH_CRLF:
            begin
                if (is_lf)
                begin
                    phase_next = PH_SIZE;
                end
                else if (!is_cr)
                begin
                    phase_next  = PH_FAIL;
                    status_next = hcbe_pkg::ST_ERR;
                end
            end
            PH_TR_HEAD:
            begin
                if (is_lf)
                begin
                    phase_next  = PH_DONE;
                    status_next = hcbe_pkg::ST_END;
                end
                else if (!is_cr)
                begin
                    phase_next = PH_TR_MID;
                end
            end
            PH_TR_MID:
            begin
                if (is_lf)
                begin
                    phase_next = PH_TR_HEAD;
                end
            end
            PH_DONE:
            begin
                status_next = hcbe_pkg::ST_IGN;
            end
            PH_FAIL:
            begin
                status_next = hcbe_pkg::ST_ERR;
            end
            default:
            begin
                status_next = hcbe_pkg::ST_ERR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE;
            cnt_reg   <= '0;
            dcnt_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                dcnt_reg  <= dcnt_next;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg  <= status_next;
            payload_reg <= payload_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_status  = status_reg;
    assign out_payload = payload_reg;

endmodule

>>> rtl/http_chunked_body_end_detector.sv
// ----------------------------------------------------------------------------
// http_chunked_body_end_detector
// Finds the end of an HTTP chunked body, one byte per transfer.
// ----------------------------------------------------------------------------
// Body bytes arrive on the s_axis channel, one byte per transfer, and each
// byte produces exactly one result transfer on the m_axis channel carrying a
// status (in progress, end of message, error, ignored after finish) and a
// flag that marks chunk payload bytes.
// A byte is held in the input register until the parser takes it, and its
// result is then registered, so a result is offered in the cycle after its
// byte is taken. One byte per cycle is sustained while m_axis_tready is high;
// the critical path is the 64-bit size counter update and its zero test
// inside the parser stage.
// When the receiver stalls, the result register holds its value and the
// input register keeps at most one waiting byte; once both are full,
// s_axis_tready follows m_axis_tready within the same cycle.
// Reset returns the parser to the start of a chunk size line, clears the
// size counter and empties both registers; skip_trailers resets to 0.
// APB register skip_trailers (address 0) decides whether trailers follow the
// last chunk; the user writes it only while the block is idle, unchecked by logic.
// ----------------------------------------------------------------------------
module http_chunked_body_end_detector
#(
    parameter int MAX_SIZE_DIGITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [1:0] status, [2] is_payload, [7:3] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    hcbe_pkg::byte_slot_t slot;
    hcbe_pkg::status_t    status;
    logic                 take;
    logic                 is_payload;
    logic                 skip_trailers_reg;
    logic                 skip_trailers_next;
    logic                 reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'(hcbe_pkg::REG_SKIP_TRAILERS));

    always_comb
    begin
        skip_trailers_next = skip_trailers_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            skip_trailers_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_trailers_reg <= 1'b0;
        end
        else
        begin
            skip_trailers_reg <= skip_trailers_next;
        end
    end

    assign prdata = reg_sel ? {31'd0, skip_trailers_reg} : 32'd0;

    hcbe_in_stage u_in_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .take          (take),
        .slot          (slot)
    );

    hcbe_parser
    #(
        .MAX_SIZE_DIGITS (MAX_SIZE_DIGITS)
    )
    u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .slot          (slot),
        .take          (take),
        .skip_trailers (skip_trailers_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_status    (status),
        .out_payload   (is_payload)
    );

    assign m_axis_tdata = {5'd0, is_payload, status};

endmodule
